// ===== src/tgo_pkg.sv =====
// ----------------------------------------------------------------------------
// tgo_pkg
// Shared widths, operand codes and the multiply-accumulate term table for
// the triangle gradient operator block.
// ----------------------------------------------------------------------------
`default_nettype none

package tgo_pkg;

  localparam int CW            = 32;
  localparam int IDXW          = 16;
  localparam int ROWW          = 18;
  localparam int CNTW          = 16;
  localparam int MAX_TRIANGLES = 65536;
  localparam int EW            = CW + 1;
  localparam int OPW           = 68;
  localparam int CHUNK         = 17;
  localparam int NCHUNK        = 4;
  localparam int ACCW          = 140;
  localparam int DETW          = 134;
  localparam int NW            = 101;
  localparam int VW            = NW + 1;
  localparam int DW            = DETW + 1;
  localparam int QW            = 34;
  localparam int DVW           = DW + QW;
  localparam int NTERMS        = 22;
  localparam int AXIS_TERM     = 18;
  localparam int TERMW         = 5;

  typedef enum logic [3:0] {
    OP_E1X, OP_E1Y, OP_E1Z, OP_E2X, OP_E2Y, OP_E2Z, OP_E1K, OP_E2K,
    OP_G11, OP_G12, OP_G22, OP_CR0, OP_CR1, OP_CR2
  } opsel_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_G11, DST_G12, DST_G22, DST_CR0, DST_CR1, DST_CR2,
    DST_DET, DST_N0, DST_N1
  } dst_t;

  typedef struct packed {
    opsel_t    a;
    opsel_t    b;
    logic      sub;
    logic      first;
    dst_t      dst;
  } term_t;

  typedef struct packed {
    logic       load;
    logic       mac;
    term_t      term;
    logic [1:0] chunk;
    logic [1:0] axis;
    logic       div_init;
    logic       div_step;
    logic [1:0] sel;
    logic       out_load;
  } cmd_t;

  function automatic term_t term_of(input logic [TERMW-1:0] idx);
    term_t t;
    case (idx)
      5'd0:    t = '{OP_E1X, OP_E1X, 1'b0, 1'b1, DST_NONE};
      5'd1:    t = '{OP_E1Y, OP_E1Y, 1'b0, 1'b0, DST_NONE};
      5'd2:    t = '{OP_E1Z, OP_E1Z, 1'b0, 1'b0, DST_G11};
      5'd3:    t = '{OP_E1X, OP_E2X, 1'b0, 1'b1, DST_NONE};
      5'd4:    t = '{OP_E1Y, OP_E2Y, 1'b0, 1'b0, DST_NONE};
      5'd5:    t = '{OP_E1Z, OP_E2Z, 1'b0, 1'b0, DST_G12};
      5'd6:    t = '{OP_E2X, OP_E2X, 1'b0, 1'b1, DST_NONE};
      5'd7:    t = '{OP_E2Y, OP_E2Y, 1'b0, 1'b0, DST_NONE};
      5'd8:    t = '{OP_E2Z, OP_E2Z, 1'b0, 1'b0, DST_G22};
      5'd9:    t = '{OP_E1Y, OP_E2Z, 1'b0, 1'b1, DST_NONE};
      5'd10:   t = '{OP_E1Z, OP_E2Y, 1'b1, 1'b0, DST_CR0};
      5'd11:   t = '{OP_E1Z, OP_E2X, 1'b0, 1'b1, DST_NONE};
      5'd12:   t = '{OP_E1X, OP_E2Z, 1'b1, 1'b0, DST_CR1};
      5'd13:   t = '{OP_E1X, OP_E2Y, 1'b0, 1'b1, DST_NONE};
      5'd14:   t = '{OP_E1Y, OP_E2X, 1'b1, 1'b0, DST_CR2};
      5'd15:   t = '{OP_CR0, OP_CR0, 1'b0, 1'b1, DST_NONE};
      5'd16:   t = '{OP_CR1, OP_CR1, 1'b0, 1'b0, DST_NONE};
      5'd17:   t = '{OP_CR2, OP_CR2, 1'b0, 1'b0, DST_DET};
      5'd18:   t = '{OP_G22, OP_E1K, 1'b0, 1'b1, DST_NONE};
      5'd19:   t = '{OP_G12, OP_E2K, 1'b1, 1'b0, DST_N0};
      5'd20:   t = '{OP_G11, OP_E2K, 1'b0, 1'b1, DST_NONE};
      5'd21:   t = '{OP_G12, OP_E1K, 1'b1, 1'b0, DST_N1};
      default: t = '{OP_E1X, OP_E1X, 1'b0, 1'b1, DST_NONE};
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== src/tgo_ctrl.sv =====
// ----------------------------------------------------------------------------
// tgo_ctrl
// Sequencer: steps the multiply-accumulate term table, runs the divider
// once per coefficient and hands out each result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tgo_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tgo_pkg::cmd_t      cmd
);
  import tgo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_DINIT, S_DIV, S_OUT, S_EMIT
  } state_t;

  state_t           state;
  logic [TERMW-1:0] term;
  logic [1:0]       chunk;
  logic [1:0]       axis;
  logic [1:0]       sel;
  logic [5:0]       cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = in_valid && (state == S_IDLE);
    cmd.mac      = (state == S_MAC);
    cmd.term     = term_of(term);
    cmd.chunk    = chunk;
    cmd.axis     = axis;
    cmd.div_init = (state == S_DINIT);
    cmd.div_step = (state == S_DIV);
    cmd.sel      = sel;
    cmd.out_load = (state == S_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      term      <= '0;
      chunk     <= '0;
      axis      <= '0;
      sel       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MAC;
            term  <= '0;
            chunk <= '0;
            axis  <= '0;
          end
        end
        S_MAC: begin
          chunk <= chunk + 2'd1;
          if (chunk == 2'(NCHUNK - 1)) begin
            if (term == TERMW'(NTERMS - 1)) begin
              state <= S_DINIT;
              sel   <= '0;
            end else begin
              term <= term + TERMW'(1);
            end
          end
        end
        S_DINIT: begin
          state <= S_DIV;
          cnt   <= 6'(QW - 1);
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_OUT;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_OUT: begin
          state     <= S_EMIT;
          out_valid <= 1'b1;
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (sel == 2'd2) begin
              if (axis == 2'd2) begin
                state <= S_IDLE;
              end else begin
                axis  <= axis + 2'd1;
                term  <= TERMW'(AXIS_TERM);
                chunk <= '0;
                state <= S_MAC;
              end
            end else begin
              sel   <= sel + 2'd1;
              state <= S_DINIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a word is pending");
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_MAC && term == '0 && axis == '0)
    else $error("bad start of triangle sequence");
  a_term_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> term < TERMW'(NTERMS))
    else $error("term index out of table");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sel) && $stable(axis))
    else $error("word position moved under stall");
`endif

endmodule

`default_nettype wire

// ===== src/tgo_datapath.sv =====
// ----------------------------------------------------------------------------
// tgo_datapath
// Edge vectors, shared 68x17 multiply-accumulate, restoring divider with
// rounding and saturation, and the result word registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tgo_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tgo_pkg::cmd_t                cmd,
  input  wire logic [tgo_pkg::CW-1:0]       ax,
  input  wire logic [tgo_pkg::CW-1:0]       ay,
  input  wire logic [tgo_pkg::CW-1:0]       az,
  input  wire logic [tgo_pkg::CW-1:0]       bx,
  input  wire logic [tgo_pkg::CW-1:0]       by,
  input  wire logic [tgo_pkg::CW-1:0]       bz,
  input  wire logic [tgo_pkg::CW-1:0]       cx,
  input  wire logic [tgo_pkg::CW-1:0]       cy,
  input  wire logic [tgo_pkg::CW-1:0]       cz,
  input  wire logic [tgo_pkg::IDXW-1:0]     vert_a,
  input  wire logic [tgo_pkg::IDXW-1:0]     vert_b,
  input  wire logic [tgo_pkg::IDXW-1:0]     vert_c,
  output logic [tgo_pkg::ROWW-1:0]          row_index,
  output logic [tgo_pkg::IDXW-1:0]          col_index,
  output logic [tgo_pkg::CW-1:0]            coeff,
  output logic                              degenerate,
  output logic                              last
);
  import tgo_pkg::*;

  logic [EW-1:0]   e1 [3];
  logic [EW-1:0]   e2 [3];
  logic [OPW-1:0]  g11, g12, g22, cr0, cr1, cr2;
  logic [DETW-1:0] det;
  logic [NW-1:0]   n0, n1;
  logic [ACCW-1:0] acc;
  logic [IDXW-1:0] cols [3];
  logic [CNTW-1:0] tri_count;
  logic [ROWW-1:0] row_base;
  logic [DW-1:0]   rem;
  logic [DVW-1:0]  dv;
  logic [QW-1:0]   q;
  logic            ovf;
  logic            neg;

  logic [EW-1:0]        e1k, e2k;
  logic [OPW-1:0]       a_op, b_op, mag_a, mag_b;
  logic [CHUNK-1:0]     chunk_b;
  logic [OPW+CHUNK-1:0] prod;
  logic [ACCW-1:0]      shifted, acc_base, acc_next;
  logic [5:0]           shamt;
  logic                 neg_p;
  logic [VW-1:0]        nv, nmag;
  logic [DW-1:0]        dnum, dden;
  logic                 ge;
  logic                 degen;
  logic [CW-1:0]        coeff_next;
  logic [CNTW:0]        cnt_inc;

  function automatic logic [OPW-1:0] sx_e(input logic [EW-1:0] v);
    return {{(OPW-EW){v[EW-1]}}, v};
  endfunction

  function automatic logic [OPW-1:0] pick(input opsel_t s, input logic [EW-1:0] k1,
                                          input logic [EW-1:0] k2);
    logic [OPW-1:0] r;
    case (s)
      OP_E1X:  r = sx_e(e1[0]);
      OP_E1Y:  r = sx_e(e1[1]);
      OP_E1Z:  r = sx_e(e1[2]);
      OP_E2X:  r = sx_e(e2[0]);
      OP_E2Y:  r = sx_e(e2[1]);
      OP_E2Z:  r = sx_e(e2[2]);
      OP_E1K:  r = sx_e(k1);
      OP_E2K:  r = sx_e(k2);
      OP_G11:  r = g11;
      OP_G12:  r = g12;
      OP_G22:  r = g22;
      OP_CR0:  r = cr0;
      OP_CR1:  r = cr1;
      OP_CR2:  r = cr2;
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    case (cmd.axis)
      2'd0:    begin e1k = e1[0]; e2k = e2[0]; end
      2'd1:    begin e1k = e1[1]; e2k = e2[1]; end
      default: begin e1k = e1[2]; e2k = e2[2]; end
    endcase
  end

  // multiply-accumulate, one 17-bit slice of b per cycle
  always_comb begin
    a_op    = pick(cmd.term.a, e1k, e2k);
    b_op    = pick(cmd.term.b, e1k, e2k);
    mag_a   = a_op[OPW-1] ? (~a_op + 1'b1) : a_op;
    mag_b   = b_op[OPW-1] ? (~b_op + 1'b1) : b_op;
    neg_p   = a_op[OPW-1] ^ b_op[OPW-1] ^ cmd.term.sub;
    chunk_b = mag_b[cmd.chunk*CHUNK +: CHUNK];
    prod    = mag_a * chunk_b;
    case (cmd.chunk)
      2'd0:    shamt = 6'd0;
      2'd1:    shamt = 6'(CHUNK);
      2'd2:    shamt = 6'(2*CHUNK);
      default: shamt = 6'(3*CHUNK);
    endcase
    shifted  = {{(ACCW-OPW-CHUNK){1'b0}}, prod} << shamt;
    acc_base = (cmd.term.first && cmd.chunk == '0) ? '0 : acc;
    acc_next = neg_p ? (acc_base - shifted) : (acc_base + shifted);
  end

  // divider operands: round(|n| / det) as (2|n| + det) / (2 det)
  always_comb begin
    case (cmd.sel)
      2'd0:    nv = ~({n0[NW-1], n0} + {n1[NW-1], n1}) + 1'b1;
      2'd1:    nv = {n0[NW-1], n0};
      default: nv = {n1[NW-1], n1};
    endcase
    nmag = nv[VW-1] ? (~nv + 1'b1) : nv;
    dnum = {{(DW-VW-1){1'b0}}, nmag, 1'b0} + {1'b0, det};
    dden = {det, 1'b0};
    ge   = {{QW{1'b0}}, rem} >= dv;
  end

  assign degen   = (det == '0);
  assign cnt_inc = {1'b0, tri_count} + 1'b1;

  always_comb begin
    if (degen) begin
      coeff_next = '0;
    end else if (!neg) begin
      coeff_next = (ovf || q > QW'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : q[CW-1:0];
    end else begin
      coeff_next = (ovf || q > QW'(33'h080000000)) ? 32'h80000000 : (~q[CW-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tri_count <= '0;
    end else if (cmd.load) begin
      tri_count <= (cnt_inc >= (CNTW+1)'(MAX_TRIANGLES)) ? '0 : cnt_inc[CNTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e1[0]    <= {bx[CW-1], bx} - {ax[CW-1], ax};
      e1[1]    <= {by[CW-1], by} - {ay[CW-1], ay};
      e1[2]    <= {bz[CW-1], bz} - {az[CW-1], az};
      e2[0]    <= {cx[CW-1], cx} - {ax[CW-1], ax};
      e2[1]    <= {cy[CW-1], cy} - {ay[CW-1], ay};
      e2[2]    <= {cz[CW-1], cz} - {az[CW-1], az};
      cols[0]  <= vert_a;
      cols[1]  <= vert_b;
      cols[2]  <= vert_c;
      row_base <= {2'b00, tri_count} + {1'b0, tri_count, 1'b0};
    end
    if (cmd.mac) begin
      acc <= acc_next;
      if (cmd.chunk == 2'(NCHUNK - 1)) begin
        case (cmd.term.dst)
          DST_G11: g11 <= acc_next[OPW-1:0];
          DST_G12: g12 <= acc_next[OPW-1:0];
          DST_G22: g22 <= acc_next[OPW-1:0];
          DST_CR0: cr0 <= acc_next[OPW-1:0];
          DST_CR1: cr1 <= acc_next[OPW-1:0];
          DST_CR2: cr2 <= acc_next[OPW-1:0];
          DST_DET: det <= acc_next[DETW-1:0];
          DST_N0:  n0  <= acc_next[NW-1:0];
          DST_N1:  n1  <= acc_next[NW-1:0];
          default: ;
        endcase
      end
    end
    if (cmd.div_init) begin
      rem <= dnum;
      dv  <= {1'b0, dden, {(QW-1){1'b0}}};
      ovf <= {{QW{1'b0}}, dnum} >= {dden, {QW{1'b0}}};
      neg <= nv[VW-1];
      q   <= '0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - dv[DW-1:0];
      end
      q  <= {q[QW-2:0], ge};
      dv <= dv >> 1;
    end
    if (cmd.out_load) begin
      row_index  <= row_base + ROWW'(cmd.axis);
      col_index  <= (cmd.sel == 2'd0) ? cols[0] : (cmd.sel == 2'd1) ? cols[1] : cols[2];
      coeff      <= coeff_next;
      degenerate <= degen;
      last       <= (cmd.axis == 2'd2) && (cmd.sel == 2'd2);
    end
  end

endmodule

`default_nettype wire

// ===== src/triangle_gradient_operator_rows.sv =====
// ----------------------------------------------------------------------------
// triangle_gradient_operator_rows
// Per triangle, nine sparse entries of the edge-matrix pseudo-inverse
// (M^T M)^-1 M^T, rounded to nearest and saturated.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              word
//  in       input      in_valid / in_ready    ax..cz, vert_a..vert_c
//  out      output     out_valid / out_ready  row_index, col_index, coeff,
//                                             degenerate, last
//
//  one triangle at a time. With a ready sink: 68x17 multiply-accumulate
//  for the Gram terms, cross product, determinant and first-axis numerators,
//  the numerator terms again per further axis, then the one-bit-per-cycle
//  divider per entry. out_ready low holds the sequence in place.
//  synchronous reset clears the sequencer and the triangle counter.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_gradient_operator_rows (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [tgo_pkg::CW-1:0]       ax,
  input  wire logic [tgo_pkg::CW-1:0]       ay,
  input  wire logic [tgo_pkg::CW-1:0]       az,
  input  wire logic [tgo_pkg::CW-1:0]       bx,
  input  wire logic [tgo_pkg::CW-1:0]       by,
  input  wire logic [tgo_pkg::CW-1:0]       bz,
  input  wire logic [tgo_pkg::CW-1:0]       cx,
  input  wire logic [tgo_pkg::CW-1:0]       cy,
  input  wire logic [tgo_pkg::CW-1:0]       cz,
  input  wire logic [tgo_pkg::IDXW-1:0]     vert_a,
  input  wire logic [tgo_pkg::IDXW-1:0]     vert_b,
  input  wire logic [tgo_pkg::IDXW-1:0]     vert_c,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tgo_pkg::ROWW-1:0]          row_index,
  output logic [tgo_pkg::IDXW-1:0]          col_index,
  output logic [tgo_pkg::CW-1:0]            coeff,
  output logic                              degenerate,
  output logic                              last
);
  import tgo_pkg::*;

  cmd_t cmd;

  tgo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tgo_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .ax         (ax),
    .ay         (ay),
    .az         (az),
    .bx         (bx),
    .by         (by),
    .bz         (bz),
    .cx         (cx),
    .cy         (cy),
    .cz         (cz),
    .vert_a     (vert_a),
    .vert_b     (vert_b),
    .vert_c     (vert_c),
    .row_index  (row_index),
    .col_index  (col_index),
    .coeff      (coeff),
    .degenerate (degenerate),
    .last       (last)
  );

endmodule

`default_nettype wire
